### rtl/rkx_pkg.sv
`default_nettype none

package rkx_pkg;

  // Longest packet in bytes; the byte at the last offset closes a packet
  localparam int MAX_PACKET_BYTES = 65535;

  localparam int KEY_W  = 64;
  localparam int BYTE_W = 8;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SESSION_KEY = 1'b1;

  // Direction codes
  localparam logic DIR_DECIPHER = 1'b0;
  localparam logic DIR_ENCIPHER = 1'b1;

  // Fixed whitening table, character 0 in the top byte
  localparam logic [64*BYTE_W-1:0] XOR_TABLE =
    "nKO/WctQ0AVLbpzfBkS6NevDYT8ourG5CRlmdjyJ72aswx4EPq1UgZhFMXH?3iI9";

  typedef struct packed {
    logic [BYTE_W-1:0] data_in;
    logic              end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              packet_done;
    logic              short_packet;
  } out_word_t;

  function automatic logic [BYTE_W-1:0] table_byte(input logic [5:0] idx);
    table_byte = XOR_TABLE[BYTE_W*(63 - int'(idx)) +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

### rtl/rolling_key_packet_xor_cipher_unit.sv
`default_nettype none

// Channel   Handshake             Payload
// src       src_valid/src_stall   rkx_pkg::in_word_t  (data_in, end_of_packet)
// dst       dst_valid/dst_stall   rkx_pkg::out_word_t (data_out, packet_done, short_packet)
// cfg       cfg_write             cfg_index, cfg_data (0 direction, 1 session key)
//
// One word per cycle while src_stall is low; a taken word's result is registered straight
// into dst unless dst is stalled, in which case it waits in the skid slot until dst frees.
// Only the XOR chain lies between the accepted word and output; the 64-bit key add feeds the key.
// A one-word skid register behind the output takes one more word from src after dst stalls;
// src_stall comes straight from that register's occupancy.
// Synchronous reset: key zero, decipher, position and chaining byte zero, both stages empty.
module rolling_key_packet_xor_cipher_unit #(
  parameter int MAX_PACKET_BYTES = rkx_pkg::MAX_PACKET_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            src_valid,
  output logic                                 src_stall,
  input  wire rkx_pkg::in_word_t               src_word,
  output logic                                 dst_valid,
  input  wire logic                            dst_stall,
  output rkx_pkg::out_word_t                   dst_word,
  input  wire logic                            cfg_write,
  input  wire logic [rkx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rkx_pkg::KEY_W-1:0]       cfg_data
);

  logic               take;
  logic               out_free;
  logic               skid_valid;
  rkx_pkg::out_word_t skid_word;
  rkx_pkg::out_word_t result;

  // word is taken whenever the skid slot is empty
  assign src_stall = skid_valid;
  assign take      = src_valid && !skid_valid;
  // output register may be reloaded this cycle
  assign out_free  = !dst_valid || !dst_stall;

  rkx_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .word     (src_word),
    .result   (result)
  );

  // control: output stage and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no word is taken while it is full
      dst_valid  <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      dst_word <= skid_valid ? skid_word : result;
    end else if (take) begin
      skid_word <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/rkx_core.sv
`default_nettype none

// Cipher state and per-byte transform; state moves on each accepted word.
module rkx_core #(
  parameter int MAX_PACKET_BYTES = rkx_pkg::MAX_PACKET_BYTES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [rkx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rkx_pkg::KEY_W-1:0]          cfg_data,
  input  wire logic                               take,
  input  wire rkx_pkg::in_word_t                  word,
  output rkx_pkg::out_word_t                      result
);

  localparam int PosW = $clog2(MAX_PACKET_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_PACKET_BYTES - 1);
  localparam logic [PosW-1:0] PosKey  = PosW'(2);

  logic                        direction;
  logic [rkx_pkg::KEY_W-1:0]   rolling_key;
  logic [rkx_pkg::KEY_W-1:0]   rolling_key_next;
  logic [rkx_pkg::BYTE_W-1:0]  prev_byte;
  logic [rkx_pkg::BYTE_W-1:0]  prev_byte_next;
  logic [PosW-1:0]             pos;
  logic [PosW-1:0]             pos_next;

  logic [PosW-1:0]             off;
  logic [2:0]                  key_idx;
  logic [rkx_pkg::BYTE_W-1:0]  key_byte;
  logic [rkx_pkg::BYTE_W-1:0]  dout;
  logic                        done;
  logic                        shortp;

  always_comb begin
    off      = pos - PosKey;
    key_idx  = 3'(off);
    key_byte = rolling_key[rkx_pkg::BYTE_W*key_idx +: rkx_pkg::BYTE_W];
    done     = word.end_of_packet || (pos >= PosLast);
    shortp   = done && (pos < PosKey);

    dout           = word.data_in;
    prev_byte_next = prev_byte;
    if (pos == PosKey) begin
      dout = word.data_in ^ key_byte;
    end else if (pos > PosKey) begin
      dout = word.data_in ^ rkx_pkg::table_byte(6'(off)) ^ key_byte ^ prev_byte;
    end
    if (pos >= PosKey) begin
      prev_byte_next = (direction == rkx_pkg::DIR_ENCIPHER) ? dout : word.data_in;
    end

    rolling_key_next = rolling_key;
    if (done && !shortp) begin
      // payload length is pos-1
      rolling_key_next = rolling_key + rkx_pkg::KEY_W'(pos - PosW'(1));
    end
    pos_next = done ? '0 : pos + PosW'(1);

    result.data_out     = dout;
    result.packet_done  = done;
    result.short_packet = shortp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= rkx_pkg::DIR_DECIPHER;
      rolling_key <= '0;
      prev_byte   <= '0;
      pos         <= '0;
    end else begin
      if (take) begin
        rolling_key <= rolling_key_next;
        prev_byte   <= prev_byte_next;
        pos         <= pos_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          rkx_pkg::REG_DIRECTION:   direction   <= cfg_data[0];
          rkx_pkg::REG_SESSION_KEY: rolling_key <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rkx_checker.sv
`default_nettype none

module rkx_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               src_valid,
  input wire logic               src_stall,
  input wire logic               dst_valid,
  input wire logic               dst_stall,
  input wire rkx_pkg::out_word_t dst_word
);

  // results held while stalled
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid)
    else $error("dst word dropped under stall");

  // input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid)
    else $error("src stalled with empty output");

  // word taken into an empty output shows next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall && !dst_valid |=> dst_valid)
    else $error("result missing one cycle after accept");

  // short flag only on a packet end
  a_short_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_word.short_packet |-> dst_word.packet_done)
    else $error("short_packet without packet_done");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid && !src_stall)
    else $error("output not empty after reset");

endmodule

bind rolling_key_packet_xor_cipher_unit rkx_checker u_rkx_checker (
  .clk      (clk),
  .rst      (rst),
  .src_valid(src_valid),
  .src_stall(src_stall),
  .dst_valid(dst_valid),
  .dst_stall(dst_stall),
  .dst_word (dst_word)
);

`default_nettype wire
